FILE: src/sidta_pkg.sv
`timescale 1ns / 1ps

package sidta_pkg;

  // Sequencer phases
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SPLIT,
    ST_EMIT
  } state_t;

  localparam int unsigned DIGIT_DEPTH = 10;
  localparam int unsigned DIGIT_IDX_W = 4;

  // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

endpackage

FILE: src/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// A value is taken in the idle state; the sequencer then splits off its digits and
// emits the text, one character per cycle while m_tready stays high.
// A new value is accepted only once the last character of the previous one has been
// issued; the shared reciprocal multiplier, producing one digit at a time, sets the pace.
// Reset: rst is synchronous, active high; clears sequencer, output valid and min_width.

module signed_int_to_decimal_ascii
  import sidta_pkg::*;
#(
  parameter int unsigned MAX_CHARS = 11
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: min_width
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value (signed)
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] character
  output logic        m_tlast
);

  localparam int unsigned CW = $clog2(MAX_CHARS + 1);
  localparam logic [CW-1:0] MAX_CW = CW'(MAX_CHARS);

  state_t state, state_next;

  logic [3:0]             min_width;
  logic [31:0]            magnitude;
  logic                   negative;
  logic [DIGIT_IDX_W-1:0] digit_count;
  logic [DIGIT_IDX_W-1:0] digit_count_next;
  logic [3:0]             digit_store [DIGIT_DEPTH];
  logic [CW-1:0]          pad;
  logic [CW-1:0]          total;
  logic [CW-1:0]          emit_pos;

  // shared divide-by-ten unit
  logic        div_load;
  logic [31:0] div_quot;
  logic [3:0]  div_rem;

  logic          in_fire;
  logic          emit_fire;
  logic          split_done;
  logic [CW-1:0] width_cap;
  logic [CW-1:0] text_len;
  logic [CW-1:0] last_pos;
  logic [CW-1:0] digit_sel;
  logic [7:0]    emit_char;

  sidta_div10 u_div10 (
    .clk       (clk),
    .load      (div_load),
    .dividend  (magnitude),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  assign digit_count_next = digit_count + 1'b1;
  // stop once the quotient reaches zero or the digit store is full
  assign split_done = (div_quot == 32'd0) ||
                      (digit_count_next == DIGIT_IDX_W'(DIGIT_DEPTH));
  assign last_pos = total - 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_SPLIT;
      end
      ST_SPLIT: begin
        state_next = split_done ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        if (emit_fire && (emit_pos == last_pos)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------
  always_comb begin
    s_tready  = 1'b0;
    div_load  = 1'b0;
    emit_fire = 1'b0;
    unique case (state)
      ST_IDLE:  s_tready  = 1'b1;
      ST_MUL:   div_load  = 1'b1;
      ST_SPLIT: ;
      ST_EMIT:  emit_fire = !m_tvalid || m_tready;  // output slot free or draining
      default: ;
    endcase
  end

  assign in_fire = s_tvalid && s_tready;

  // ---------------------------------------------------------------------
  // Padding: total length is the larger of capped width and text length
  // ---------------------------------------------------------------------
  assign width_cap = (CW'(min_width) > MAX_CW) ? MAX_CW : CW'(min_width);
  assign text_len  = CW'(digit_count_next) + CW'(negative);

  // ---------------------------------------------------------------------
  // Character select: spaces, then minus, then digits most significant first
  // ---------------------------------------------------------------------
  assign digit_sel = last_pos - emit_pos;

  always_comb begin
    if (emit_pos < pad) begin
      emit_char = CHAR_SPACE;
    end else if (negative && (emit_pos == pad)) begin
      emit_char = CHAR_MINUS;
    end else begin
      emit_char = CHAR_ZERO + {4'd0, digit_store[digit_sel[DIGIT_IDX_W-1:0]]};
    end
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      min_width <= 4'd0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) min_width <= cfg_wdata;
      if (emit_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;   // drop once the sink takes the transaction
      end
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      negative    <= s_tdata[31];
      magnitude   <= s_tdata[31] ? (32'd0 - s_tdata) : s_tdata;
      digit_count <= '0;
    end
    if (state == ST_SPLIT) begin
      digit_store[digit_count] <= div_rem;
      magnitude                <= div_quot;
      if (split_done) begin
        // hold count of digits minus one in the count register
        pad      <= (width_cap > text_len) ? (width_cap - text_len) : '0;
        total    <= (width_cap > text_len) ? width_cap : text_len;
        emit_pos <= '0;
      end else begin
        digit_count <= digit_count_next;
      end
    end
    if (emit_fire) begin
      m_tdata  <= emit_char;
      m_tlast  <= (emit_pos == last_pos);
      emit_pos <= emit_pos + 1'b1;
    end
  end

endmodule

FILE: src/sidta_div10.sv
`timescale 1ns / 1ps

module sidta_div10
  import sidta_pkg::*;
(
  input  logic        clk,
  input  logic        load,
  input  logic [31:0] dividend,
  output logic [31:0] quotient,
  output logic [3:0]  remainder
);

  logic [63:0] prod;
  logic [31:0] held;
  logic [31:0] times_ten;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= {32'd0, dividend} * {32'd0, RECIP_TEN};
      held <= dividend;
    end
  end

  assign quotient  = {{(RECIP_SHIFT - 32){1'b0}}, prod[63:RECIP_SHIFT]};
  assign times_ten = {quotient[28:0], 3'b000} + {quotient[30:0], 1'b0};

  // remainder is below ten, so the low nibble of the difference is exact
  assign remainder = held[3:0] - times_ten[3:0];

endmodule

FILE: dv/signed_int_to_decimal_ascii_test.sv
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_test;
  import sidta_pkg::*;

  localparam int unsigned TEXT_MAX    = 11;      // matches the block's default MAX_CHARS
  localparam int unsigned SETTLE_CYC  = 40;      // settle time after the last owed character
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned LONG_STALL  = 300;
  localparam int unsigned BLOCK_ITEMS = 11;      // random values per min_width setting

  // One expected character of the output text
  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  // Directed stimulus: width to configure, value to send, and the text when it is
  // obvious by inspection (empty string: take the predictor's text)
  typedef struct {
    logic [3:0] width;
    int         value;
    string      text;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] value (signed)
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [7:0] character
  logic        m_tlast;

  text_char_t  pending_chars[$];   // characters still owed by the block, oldest first
  text_char_t  got_char;
  dir_row_t    dir_rows[$];
  logic [3:0]  pad_width;          // predictor's copy of min_width
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_left;
  bit          long_stall_req;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  signed_int_to_decimal_ascii uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Count cycles and abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic note_mismatch(input string what);
    if (mismatch_count < 50)
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Predict the text of one value: padding spaces, minus sign, digits
  // most significant first; last marks the final character.
  function automatic void predict_text(input logic [31:0] value, input logic [3:0] width);
    logic [31:0] mag;
    logic [3:0]  digits[10];
    int unsigned n_digits;
    int unsigned cap;
    int unsigned text_len;
    int unsigned pad;
    int unsigned total;
    int unsigned k;
    text_char_t  c;
    n_digits = 0;
    k = 0;
    // Form the magnitude as unsigned so the most negative value survives
    mag = value[31] ? (32'd0 - value) : value;
    do begin
      digits[n_digits] = 4'(mag % 10);
      n_digits++;
      mag = mag / 10;
    end while (mag != 0 && n_digits < 10);
    // Clamp widths above the cap
    cap = (width > TEXT_MAX) ? TEXT_MAX : width;
    text_len = n_digits + value[31];
    pad = (cap > text_len) ? cap - text_len : 0;
    total = pad + text_len;
    repeat (pad) begin
      k++;
      c.ch = CHAR_SPACE;
      c.last = (k == total);
      pending_chars.push_back(c);
    end
    if (value[31]) begin
      k++;
      c.ch = CHAR_MINUS;
      c.last = (k == total);
      pending_chars.push_back(c);
    end
    for (int i = int'(n_digits) - 1; i >= 0; i--) begin
      k++;
      c.ch = CHAR_ZERO + 8'(digits[i]);
      c.last = (k == total);
      pending_chars.push_back(c);
    end
  endfunction

  // Queue a text typed in by hand
  function automatic void queue_literal(input string text);
    text_char_t c;
    for (int i = 0; i < text.len(); i++) begin
      c.ch = text[i];
      c.last = (i == text.len() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  // Random value: mostly sized magnitudes so every digit count shows up,
  // plus full-range words and the boundaries.
  function automatic logic [31:0] pick_value();
    int unsigned kind;
    int unsigned n;
    logic [31:0] limit;
    logic [31:0] mag;
    kind = $urandom_range(0, 9);
    limit = 32'd1;
    if (kind < 3)
      return $urandom;
    if (kind < 8) begin
      n = $urandom_range(1, 9);
      repeat (n) limit = limit * 10;
      mag = $urandom % limit;
      return ($urandom_range(0, 1) == 1) ? 32'd0 - mag : mag;
    end
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0001;
      3: return 32'd1_000_000_000;
      4: return 32'd0 - 32'd999_999_999;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // All stimulus tasks start and end just after a falling edge.

  // Offer one value; hold tvalid high until the transaction completes.
  task automatic send_value(input logic [31:0] value, input string text);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      s_tdata = $urandom;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = value;
    do @(posedge clk); while (!s_tready);
    if (text.len() != 0)
      queue_literal(text);
    else
      predict_text(value, pad_width);
    @(negedge clk);
  endtask

  // Drop tvalid, wait for every owed character, then let the block settle
  task automatic drain();
    s_tvalid = 1'b0;
    while (pending_chars.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_width(input logic [3:0] width);
    cfg_we = 1'b1;
    cfg_wdata = width;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_wdata = 4'($urandom);
    pad_width = width;
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        stall_left = LONG_STALL;
      end
      if (stall_left != 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Compare each accepted character with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_chars.size() == 0) begin
        note_mismatch($sformatf("unexpected character 0x%02h last=%0b", m_tdata, m_tlast));
      end else begin
        got_char = pending_chars.pop_front();
        if (m_tdata !== got_char.ch)
          note_mismatch($sformatf("character 0x%02h, want 0x%02h", m_tdata, got_char.ch));
        if (m_tlast !== got_char.last)
          note_mismatch($sformatf("last %0b, want %0b", m_tlast, got_char.last));
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 4'd0;
    s_tvalid = 1'b0;
    s_tdata = 32'd0;
    m_tready = 1'b0;
    pad_width = 4'd0;
    send_idle_pct = 6;
    recv_idle_pct = 81;
    stall_left = 0;
    long_stall_req = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;

    dir_rows = '{
      '{4'd0,  0,             "0"},
      '{4'd0,  2147483647,    "2147483647"},
      '{4'd0,  32'h8000_0000, "-2147483648"},
      '{4'd0,  -1,            "-1"},
      '{4'd0,  9,             ""},
      '{4'd0,  10,            ""},
      '{4'd0,  -10,           ""},
      '{4'd0,  99999,         ""},
      '{4'd0,  32'h5555_5555, ""},
      '{4'd0,  32'hAAAA_AAAA, ""},
      '{4'd4,  7,             "   7"},
      '{4'd4,  -7,            "  -7"},
      // width below the text length: no padding, no truncation
      '{4'd4,  12345,         "12345"},
      '{4'd11, 0,             "          0"},
      '{4'd11, 32'h8000_0000, "-2147483648"},
      '{4'd11, 123,           ""},
      // widths above the cap act as eleven
      '{4'd15, 5,             "          5"},
      '{4'd15, -5,            ""},
      '{4'd12, 1000000000,    ""},
      '{4'd1,  -9,            ""},
      '{4'd10, 2147483647,    ""}
    };

    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed part: reconfigure only while the block is idle
    write_width(4'd0);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].width != pad_width) begin
        drain();
        write_width(dir_rows[i].width);
      end
      send_value(dir_rows[i].value, dir_rows[i].text);
    end

    // Random part: three idling profiles, each a few blocks of one width
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 81 : 0;
      recv_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 6 : 0;
      for (int blk = 0; blk < 3; blk++) begin
        drain();
        write_width(4'($urandom_range(0, 15)));
        // Hold the receiver off while values keep coming so the input backs up
        if (ph == 2 && blk == 0)
          long_stall_req = 1'b1;
        repeat (BLOCK_ITEMS) send_value(pick_value(), "");
      end
    end

    drain();
    if (pending_chars.size() != 0)
      note_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/sidta_pkg.sv
src/sidta_div10.sv
src/signed_int_to_decimal_ascii.sv
dv/signed_int_to_decimal_ascii_test.sv
